[src/gwic_pkg.sv]
`timescale 1ns / 1ps

package gwic_pkg;

    localparam int GRID_SIDE_DEF = 1024;

    localparam int COORD_W = 10;
    localparam int STEPS_W = 16;
    localparam int COUNT_W = 32;
    localparam int HEAD_W  = 2;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    localparam logic [HEAD_W-1:0] DIR_UP    = 2'd0;
    localparam logic [HEAD_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [HEAD_W-1:0] DIR_LEFT  = 2'd3;

    typedef logic [HEAD_W-1:0]  heading_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

[src/gwic_grid.sv]
`timescale 1ns / 1ps

module gwic_grid #(
    parameter int GRID_SIDE = gwic_pkg::GRID_SIDE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(GRID_SIDE)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(GRID_SIDE)-1:0] wr_addr,
    input  logic [GRID_SIDE-1:0]         wr_data,
    output logic [GRID_SIDE-1:0]         rd_data
);

    logic [GRID_SIDE-1:0] mem [GRID_SIDE];
    logic [GRID_SIDE-1:0] q_reg;
    logic [GRID_SIDE-1:0] fwd_reg;
    logic                 hit_reg;
    logic                 hit_next;

    // one row per word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
        if (rd_en && hit_next)
        begin
            fwd_reg <= wr_data;
        end
    end

    // read of the row being written in the same cycle
    assign hit_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign rd_data = hit_reg ? fwd_reg : q_reg;

endmodule

[src/grid_walker_infection_counter.sv]
`timescale 1ns / 1ps

// set-cell: S_REDUCE takes GRID_SIDE off each out-of-range coordinate until both
//   are in range, then S_SETW writes; a run of zero steps reports from idle
// throughput: one walker step per cycle, set by the registered grid row read,
//   with same-row forwarding when the walker moves sideways
// reset: a clearing pass writes GRID_SIDE rows, one a cycle, with busy high;
//   done strobes each result for one cycle, the receiver cannot stall
module grid_walker_infection_counter #(
    parameter int GRID_SIDE = gwic_pkg::GRID_SIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [gwic_pkg::COORD_W-1:0]  cell_row,
    input  logic [gwic_pkg::COORD_W-1:0]  cell_col,
    input  logic                          cell_infected,
    input  logic [gwic_pkg::STEPS_W-1:0]  steps,
    output logic                          done,
    output logic [gwic_pkg::COUNT_W-1:0]  infections,
    output logic [gwic_pkg::COORD_W-1:0]  walker_row,
    output logic [gwic_pkg::COORD_W-1:0]  walker_col,
    output logic [gwic_pkg::HEAD_W-1:0]   heading
);

    localparam int CW = $clog2(GRID_SIDE);
    localparam logic [CW-1:0] LAST   = CW'(GRID_SIDE - 1);
    localparam logic [CW-1:0] CENTRE = CW'(GRID_SIDE / 2);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_SETW   = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [CW-1:0]                  clr_reg, clr_next;
    logic [CW-1:0]                  pos_row_reg, pos_row_next;
    logic [CW-1:0]                  pos_col_reg, pos_col_next;
    gwic_pkg::heading_t             facing_reg, facing_next;
    gwic_pkg::count_t               count_reg, count_next;
    logic [gwic_pkg::STEPS_W-1:0]   left_reg, left_next;
    logic [gwic_pkg::COORD_W-1:0]   set_row_reg, set_row_next;
    logic [gwic_pkg::COORD_W-1:0]   set_col_reg, set_col_next;
    logic                           set_val_reg, set_val_next;
    logic                           done_reg, done_next;

    logic                 rd_en;
    logic [CW-1:0]        rd_addr;
    logic                 wr_en;
    logic [CW-1:0]        wr_addr;
    logic [GRID_SIDE-1:0] wr_data;
    logic [GRID_SIDE-1:0] rd_data;

    logic                 cell_bit;
    gwic_pkg::heading_t   turn;
    logic [CW-1:0]        mv_row, mv_col;
    logic                 row_big, col_big;
    logic [CW-1:0]        set_row_a, set_col_a;

    gwic_grid #(
        .GRID_SIDE (GRID_SIDE)
    ) u_grid (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // one walker step from the row just read
    always_comb
    begin
        cell_bit = rd_data[pos_col_reg];
        turn = cell_bit ? gwic_pkg::heading_t'(facing_reg + 2'd1)
                        : gwic_pkg::heading_t'(facing_reg - 2'd1);
        mv_row = pos_row_reg;
        mv_col = pos_col_reg;
        case (turn)
            gwic_pkg::DIR_UP:    mv_row = (pos_row_reg == '0) ? LAST : pos_row_reg - 1'b1;
            gwic_pkg::DIR_RIGHT: mv_col = (pos_col_reg >= LAST) ? '0 : pos_col_reg + 1'b1;
            gwic_pkg::DIR_DOWN:  mv_row = (pos_row_reg >= LAST) ? '0 : pos_row_reg + 1'b1;
            default:             mv_col = (pos_col_reg == '0) ? LAST : pos_col_reg - 1'b1;
        endcase
    end

    assign row_big   = 32'(set_row_reg) >= 32'(GRID_SIDE);
    assign col_big   = 32'(set_col_reg) >= 32'(GRID_SIDE);
    assign set_row_a = CW'(set_row_reg);
    assign set_col_a = CW'(set_col_reg);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        pos_row_next = pos_row_reg;
        pos_col_next = pos_col_reg;
        facing_next  = facing_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        set_row_next = set_row_reg;
        set_col_next = set_col_reg;
        set_val_next = set_val_reg;
        done_next    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = pos_row_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_row_reg;
        wr_data      = rd_data;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    set_row_next = cell_row;
                    set_col_next = cell_col;
                    set_val_next = cell_infected;
                    left_next    = steps;
                    if (cmd == gwic_pkg::CMD_SET)
                    begin
                        state_next = S_REDUCE;
                    end
                    else if (steps == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_row_reg;
                        state_next = S_STEP;
                    end
                end
            end
            S_REDUCE:
            begin
                if (row_big || col_big)
                begin
                    if (row_big)
                    begin
                        set_row_next = set_row_reg - gwic_pkg::COORD_W'(GRID_SIDE);
                    end
                    if (col_big)
                    begin
                        set_col_next = set_col_reg - gwic_pkg::COORD_W'(GRID_SIDE);
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = set_row_a;
                    state_next = S_SETW;
                end
            end
            S_SETW:
            begin
                wr_en              = 1'b1;
                wr_addr            = set_row_a;
                wr_data            = rd_data;
                wr_data[set_col_a] = set_val_reg;
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end
            S_STEP:
            begin
                wr_en                = 1'b1;
                wr_addr              = pos_row_reg;
                wr_data              = rd_data;
                wr_data[pos_col_reg] = !cell_bit;
                if (!cell_bit && (count_reg != '1))
                begin
                    count_next = count_reg + 1'b1;
                end
                facing_next  = turn;
                pos_row_next = mv_row;
                pos_col_next = mv_col;
                left_next    = left_reg - 1'b1;
                if (left_reg == gwic_pkg::STEPS_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = mv_row;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pos_row_reg <= CENTRE;
            pos_col_reg <= CENTRE;
            facing_reg  <= gwic_pkg::DIR_UP;
            count_reg   <= '0;
            left_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
            facing_reg  <= facing_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_row_reg <= set_row_next;
        set_col_reg <= set_col_next;
        set_val_reg <= set_val_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign infections = count_reg;
    assign walker_row = gwic_pkg::COORD_W'(pos_row_reg);
    assign walker_col = gwic_pkg::COORD_W'(pos_col_reg);
    assign heading    = facing_reg;

    // accepted transaction either starts work or reports at once
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted transaction neither busy nor reported");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> left_reg != '0)
        else $error("step state with no steps left");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("infection count went down");

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_row_reg) < 32'(GRID_SIDE) && 32'(pos_col_reg) < 32'(GRID_SIDE))
        else $error("walker off the grid");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_STEP && state_reg != S_IDLE |=> $stable(count_reg))
        else $error("count changed outside a walk");

endmodule
